>>> rtl/core/formula_node_intern_table_top_defines.svh
// assertion macros shared by the node table rtl
`ifndef FORMULA_NODE_INTERN_TABLE_TOP_DEFINES_SVH
`define FORMULA_NODE_INTERN_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FNIT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FNIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/fnit_pkg.sv
// shared types and constants for the formula node intern table
package fnit_pkg;

    localparam int TABLE_DEPTH_DEF   = 256;
    localparam int OPERAND_WIDTH_DEF = 16;

    localparam int OPCODE_W     = 4;
    localparam int ARG_W        = 16;
    localparam int NODE_INDEX_W = 8;
    localparam int OUTCOME_W    = 2;

    // operator codes
    localparam logic [OPCODE_W-1:0] OP_PROP    = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_TRUE    = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_FALSE   = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_NOT     = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_NEXT    = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_AND     = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_OR      = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_UNTIL   = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 4'd8;

    // result outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_FOUND = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_NEW   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHILD_A,
        S_CHILD_B,
        S_INSERT
    } t_state;

    // datapath status toward the sequencer
    typedef struct packed {
        logic start;
        logic empty;
        logic hit;
        logic last;
        logic full;
    } t_stat;

    // sequencer controls toward the datapath
    typedef struct packed {
        logic busy;
        logic load;
        logic scan_issue;
        logic sel_a;
        logic sel_b;
        logic cap_flag_a;
        logic emit_hit;
        logic emit_full;
        logic do_insert;
    } t_ctrl;

endpackage

>>> rtl/core/fnit_ram.sv
// generic simple dual-port ram with registered read
module fnit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/fnit_fsm.sv
// sequencer for search, child flag reads and insertion
module fnit_fsm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fnit_pkg::t_stat i_stat,
    output fnit_pkg::t_ctrl o_ctrl
);
    import fnit_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_stat.start) begin
                    n_state = i_stat.empty ? S_CHILD_A : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_state = S_IDLE;
                end else if (i_stat.last) begin
                    n_state = i_stat.full ? S_IDLE : S_CHILD_A;
                end
            end
            S_CHILD_A: n_state = S_CHILD_B;
            S_CHILD_B: n_state = S_INSERT;
            S_INSERT:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_ctrl.busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_ctrl.load = i_stat.start;
            end
            S_SCAN: begin
                o_ctrl.scan_issue = 1'b1;
                o_ctrl.emit_hit   = i_stat.hit;
                o_ctrl.emit_full  = !i_stat.hit && i_stat.last && i_stat.full;
            end
            S_CHILD_A: begin
                o_ctrl.sel_a = 1'b1;
            end
            S_CHILD_B: begin
                o_ctrl.sel_b      = 1'b1;
                o_ctrl.cap_flag_a = 1'b1;
            end
            S_INSERT: begin
                o_ctrl.do_insert = 1'b1;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/formula_node_intern_table_top.sv
// top level of the formula node intern table: datapath, table ram and sequencer
// Interns formula nodes. A transaction is taken on a clock edge with start high and busy
// low. The stored nodes are compared in insertion order, one table ram read per cycle,
// and the first hit ends the search and is reported. On a miss, two more ram reads fetch
// the children's flags and the node is then written in the insert state; an empty table
// skips the search, and a table holding TABLE_DEPTH nodes answers a miss with a full
// status. The single result appears in the cycle after the decision with o_strobe high
// for one cycle and cannot be held off. busy is low again in that same cycle, so the next
// transaction may start while the result is shown. No clearing pass follows reset: flags
// beyond the fill count read as cleared.
`include "formula_node_intern_table_top_defines.svh"

module formula_node_intern_table_top #(
    parameter int TABLE_DEPTH   = fnit_pkg::TABLE_DEPTH_DEF,
    parameter int OPERAND_WIDTH = fnit_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic        [fnit_pkg::OPCODE_W-1:0]     i_operator_code,
    input  logic signed [fnit_pkg::ARG_W-1:0]        i_first_operand,
    input  logic signed [fnit_pkg::ARG_W-1:0]        i_second_operand,
    output logic                                     o_strobe,
    output logic        [fnit_pkg::NODE_INDEX_W-1:0] o_node_index,
    output logic        [fnit_pkg::OUTCOME_W-1:0]    o_outcome,
    output logic                                     o_is_propositional
);
    import fnit_pkg::*;

    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int OW   = OPERAND_WIDTH;
    localparam int DW   = OPCODE_W + 2 * OW + 1;
    localparam int CMPW = (CW > ARG_W) ? CW : ARG_W;

    t_ctrl ctrl;
    t_stat stat;

    logic [OPCODE_W-1:0]     r_op;
    logic [ARG_W-1:0]        r_a_raw;
    logic [ARG_W-1:0]        r_b_raw;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_addr;
    logic [CW-1:0]           r_vidx;
    logic                    r_vld;
    logic                    r_flag_a;
    logic                    r_o_valid;
    logic [NODE_INDEX_W-1:0] r_o_idx;
    logic [OUTCOME_W-1:0]    r_o_outcome;
    logic                    r_o_flag;
    logic                    n_flag;

    logic [IW-1:0]       raddr;
    logic [DW-1:0]       rd_data;
    logic [DW-1:0]       wr_data;
    logic [OPCODE_W-1:0] rd_op;
    logic [OW-1:0]       rd_a;
    logic [OW-1:0]       rd_b;
    logic                rd_flag;
    logic [OW-1:0]       key_a;
    logic [OW-1:0]       key_b;
    logic                is_prop;
    logic                match;
    logic                last_idx;
    logic                issue_ok;
    logic                a_ok;
    logic                b_ok;
    logic                tbl_full;
    logic [CW-1:0]       count_inc;
    logic                full_out;

    // unpack the ram word: operator, first operand, second operand, flag
    assign rd_op   = rd_data[DW-1 -: OPCODE_W];
    assign rd_a    = rd_data[2*OW -: OW];
    assign rd_b    = rd_data[OW -: OW];
    assign rd_flag = rd_data[0];

    assign is_prop = (r_op == OP_PROP);
    assign key_a   = OW'(r_a_raw);
    assign key_b   = is_prop ? '0 : OW'(r_b_raw);

    assign match    = (rd_op == r_op) && (rd_a == key_a) && (is_prop || (rd_b == key_b));
    assign last_idx = ((r_vidx + CW'(1)) == r_count);
    assign issue_ok = (r_addr < r_count);
    assign tbl_full = (r_count == CW'(TABLE_DEPTH));

    // a child index below the fill count has a written flag, anything else reads as cleared
    assign a_ok = !r_a_raw[ARG_W-1] && (CMPW'(r_a_raw[ARG_W-2:0]) < CMPW'(r_count));
    assign b_ok = !r_b_raw[ARG_W-1] && (CMPW'(r_b_raw[ARG_W-2:0]) < CMPW'(r_count));

    always_comb begin
        if (ctrl.sel_a) begin
            raddr = r_a_raw[IW-1:0];
        end else if (ctrl.sel_b) begin
            raddr = r_b_raw[IW-1:0];
        end else begin
            raddr = r_addr[IW-1:0];
        end
    end

    // in the insert cycle the ram output holds the second child's entry
    always_comb begin
        case (r_op)
            OP_PROP, OP_TRUE, OP_FALSE: n_flag = 1'b1;
            OP_NOT:                     n_flag = r_flag_a;
            OP_AND, OP_OR:              n_flag = r_flag_a & b_ok & rd_flag;
            default:                    n_flag = 1'b0;
        endcase
    end

    assign wr_data = {r_op, key_a, key_b, n_flag};

    assign stat.start = start;
    assign stat.empty = (r_count == '0);
    assign stat.hit   = r_vld && match;
    assign stat.last  = r_vld && last_idx;
    assign stat.full  = tbl_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_addr    <= '0;
            r_vld     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= ctrl.emit_hit || ctrl.emit_full || ctrl.do_insert;
            r_vld     <= ctrl.scan_issue && issue_ok;
            if (ctrl.load) begin
                r_addr <= '0;
            end else if (ctrl.scan_issue && issue_ok) begin
                r_addr <= r_addr + CW'(1);
            end
            if (ctrl.do_insert) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_op    <= i_operator_code;
            r_a_raw <= i_first_operand;
            r_b_raw <= i_second_operand;
        end
        r_vidx <= r_addr;
        if (ctrl.cap_flag_a) begin
            r_flag_a <= a_ok & rd_flag;
        end
        if (ctrl.emit_hit) begin
            r_o_idx     <= NODE_INDEX_W'(r_vidx);
            r_o_outcome <= OUT_FOUND;
            r_o_flag    <= rd_flag;
        end else if (ctrl.emit_full) begin
            r_o_idx     <= '0;
            r_o_outcome <= OUT_FULL;
            r_o_flag    <= 1'b0;
        end else if (ctrl.do_insert) begin
            r_o_idx     <= NODE_INDEX_W'(r_count);
            r_o_outcome <= OUT_NEW;
            r_o_flag    <= n_flag;
        end
    end

    fnit_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.do_insert),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    fnit_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    assign busy               = ctrl.busy;
    assign o_strobe           = r_o_valid;
    assign o_node_index       = r_o_idx;
    assign o_outcome          = r_o_outcome;
    assign o_is_propositional = r_o_flag;

    assign count_inc = r_count + CW'(1);
    assign full_out  = o_strobe && (o_outcome == OUT_FULL);

    `FNIT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(TABLE_DEPTH), "fill count past depth")
    `FNIT_ASSERT_NEXT(a_insert_grows, ctrl.do_insert, r_count == $past(count_inc), "count stuck")
    `FNIT_ASSERT_NOW(a_full_only_full, full_out, tbl_full, "full status on non-full table")
    `FNIT_ASSERT_NOW(a_no_insert_full, ctrl.do_insert, !tbl_full, "insert into full table")
    `FNIT_ASSERT_NEXT(a_single_strobe, o_strobe, !o_strobe, "back-to-back result strobes")

endmodule
